// ----- rtl/pvlr_pkg.sv -----
// shared constants, types and controller/datapath command and status structs for the
// path violation length ratio block; no dependencies
package pvlr_pkg;

  localparam int JOINTS     = 6;
  localparam int POS_W      = 24;
  localparam int DIFF_W     = POS_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SQ_W       = 52;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int SUM_W      = 40;
  localparam int RATIO_FRAC = 16;
  localparam int RATIO_W    = RATIO_FRAC + 1;
  localparam int CNT_W      = 5;
  localparam int JIDX_W     = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    logic              load;
    logic              sq_mul;
    logic              sq_acc;
    logic [JIDX_W-1:0] joint;
    logic              root_init;
    logic              root_step;
    logic              accum;
    logic              div_step;
    logic              div_first;
    logic              out_load;
    logic              clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic last;
    logic len_zero;
  } dp_status_t;

endpackage

// ----- rtl/pvlr_if.sv -----
// request channels of the path violation length ratio block
// depends on pvlr_pkg
interface pvlr_in_if;
  logic          valid;
  logic          ready;
  pvlr_pkg::pos_t position_0;
  pvlr_pkg::pos_t position_1;
  pvlr_pkg::pos_t position_2;
  pvlr_pkg::pos_t position_3;
  pvlr_pkg::pos_t position_4;
  pvlr_pkg::pos_t position_5;
  logic          edge_valid;
  logic          last_point;

  modport source (output valid, position_0, position_1, position_2, position_3,
                  position_4, position_5, edge_valid, last_point, input ready);
  modport sink (input valid, position_0, position_1, position_2, position_3,
                position_4, position_5, edge_valid, last_point, output ready);
endinterface

interface pvlr_out_if;
  logic                            valid;
  logic                            ready;
  logic [pvlr_pkg::RATIO_W-1:0]    violation_ratio;
  logic [pvlr_pkg::SUM_W-1:0]      path_length;

  modport source (output valid, violation_ratio, path_length, input ready);
  modport sink (input valid, violation_ratio, path_length, output ready);
endinterface

// ----- rtl/pvlr_dp.sv -----
// datapath: point registers, shared squarer, bit-serial square root,
// saturating sums, restoring divider and result register; uses pvlr_pkg
module pvlr_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pvlr_pkg::ctrl_cmd_t           cmd,
  input  pvlr_pkg::pos_t                pos_in [pvlr_pkg::JOINTS],
  input  logic                          edge_valid_in,
  input  logic                          last_in,
  output pvlr_pkg::dp_status_t          status,
  output logic [pvlr_pkg::RATIO_W-1:0]  ratio_out,
  output logic [pvlr_pkg::SUM_W-1:0]    total_out
);

  pvlr_pkg::pos_t cur_r  [pvlr_pkg::JOINTS];
  pvlr_pkg::pos_t prev_r [pvlr_pkg::JOINTS];
  logic                           valid_r, last_r, have_prev_r;
  logic [pvlr_pkg::PROD_W-1:0]    prod_r;
  logic [pvlr_pkg::SQ_W-1:0]      acc_r, x_r, res_r, bit_r;
  logic [pvlr_pkg::SUM_W-1:0]     len_r, inv_r, rem_r;
  logic [pvlr_pkg::RATIO_W-1:0]   q_r;
  logic [pvlr_pkg::RATIO_W-1:0]   ratio_r;
  logic [pvlr_pkg::SUM_W-1:0]     total_r;

  logic signed [pvlr_pkg::DIFF_W-1:0] diff;
  logic [pvlr_pkg::DIFF_W-1:0]        mag;
  logic [pvlr_pkg::SQ_W-1:0]          trial_root;
  logic [pvlr_pkg::ROOT_W-1:0]        root;
  logic [pvlr_pkg::SUM_W:0]           len_sum, inv_sum;
  logic [pvlr_pkg::SUM_W:0]           trial_div;
  logic                               div_ge;

  always_comb begin
    diff = pvlr_pkg::DIFF_W'(cur_r[cmd.joint]) - pvlr_pkg::DIFF_W'(prev_r[cmd.joint]);
    mag  = diff[pvlr_pkg::DIFF_W-1] ? pvlr_pkg::DIFF_W'(-diff) : pvlr_pkg::DIFF_W'(diff);
    trial_root = res_r + bit_r;
    root    = res_r[pvlr_pkg::ROOT_W-1:0];
    len_sum = {1'b0, len_r} + (pvlr_pkg::SUM_W+1)'(root);
    inv_sum = {1'b0, inv_r} + (pvlr_pkg::SUM_W+1)'(root);
    trial_div = cmd.div_first ? {1'b0, inv_r} : {rem_r, 1'b0};
    div_ge    = trial_div >= {1'b0, len_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r   <= pos_in;
      valid_r <= edge_valid_in;
      last_r  <= last_in;
      prod_r  <= '0;
      acc_r   <= '0;
    end else begin
      if (cmd.sq_mul) prod_r <= mag * mag;
      if (cmd.sq_acc) acc_r <= acc_r + pvlr_pkg::SQ_W'(prod_r);
    end
    if (cmd.root_init) begin
      x_r   <= acc_r;
      res_r <= '0;
      bit_r <= pvlr_pkg::SQ_W'(1) << (pvlr_pkg::SQ_W - 2);
    end else if (cmd.root_step) begin
      if (x_r >= trial_root) begin
        x_r   <= x_r - trial_root;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.accum) prev_r <= cur_r;
    if (cmd.div_step) begin
      rem_r <= div_ge ? pvlr_pkg::SUM_W'(trial_div - {1'b0, len_r})
                      : pvlr_pkg::SUM_W'(trial_div);
      q_r   <= {q_r[pvlr_pkg::RATIO_W-2:0], div_ge};
    end
    if (cmd.out_load) begin
      ratio_r <= (len_r == '0) ? '0 : q_r;
      total_r <= len_r;
    end
  end

  // running sums and the path-open flag, cleared at reset and when a result is loaded
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      have_prev_r <= 1'b0;
      len_r       <= '0;
      inv_r       <= '0;
    end else if (cmd.accum) begin
      have_prev_r <= 1'b1;
      if (have_prev_r) begin
        len_r <= len_sum[pvlr_pkg::SUM_W] ? pvlr_pkg::SUM_MAX : len_sum[pvlr_pkg::SUM_W-1:0];
        if (!valid_r)
          inv_r <= inv_sum[pvlr_pkg::SUM_W] ? pvlr_pkg::SUM_MAX : inv_sum[pvlr_pkg::SUM_W-1:0];
      end
    end
  end

  assign status.have_prev = have_prev_r;
  assign status.last      = last_r;
  assign status.len_zero  = (len_r == '0);
  assign ratio_out = ratio_r;
  assign total_out = total_r;

endmodule

// ----- rtl/pvlr_ctrl.sv -----
// controller: sequences squaring, square root and accumulation for each point
// and division for the last point of a path, and holds the result valid flag; uses pvlr_pkg
module pvlr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  pvlr_pkg::dp_status_t  status,
  output pvlr_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_FLUSH, S_RINIT, S_ROOT, S_ACC, S_CHK, S_DIV, S_OUT
  } state_t;

  localparam logic [pvlr_pkg::CNT_W-1:0] SQ_LAST   = pvlr_pkg::CNT_W'(pvlr_pkg::JOINTS - 1);
  localparam logic [pvlr_pkg::CNT_W-1:0] ROOT_LAST = pvlr_pkg::CNT_W'(pvlr_pkg::ROOT_W - 1);
  localparam logic [pvlr_pkg::CNT_W-1:0] DIV_LAST  = pvlr_pkg::CNT_W'(pvlr_pkg::RATIO_W - 1);

  state_t                      state_r, state_nxt;
  logic [pvlr_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.joint     = cnt_r[pvlr_pkg::JIDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = status.have_prev ? S_SQ : S_ACC;
        end
      end
      S_SQ: begin
        cmd.sq_mul = 1'b1;
        cmd.sq_acc = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == SQ_LAST) state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.sq_acc = 1'b1;
        state_nxt  = S_RINIT;
      end
      S_RINIT: begin
        cmd.root_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == ROOT_LAST) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        cnt_nxt   = '0;
        state_nxt = status.last ? S_CHK : S_IDLE;
      end
      S_CHK: begin
        state_nxt = status.len_zero ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_r == '0);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          cmd.clear     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/path_violation_length_ratio.sv -----
// A path point is taken only while the block is idle. A point that closes an
// edge passes through the shared squarer one joint at a time, then through
// the bit-serial square root and the accumulation step; the first point of a
// path goes straight to accumulation. A last point adds a check step, the
// restoring divider (skipped for a zero-length path) and a step that loads
// the result register once it is free; that register may still be waiting
// for the sink while the next path starts.
module path_violation_length_ratio (
  input  logic       clk,
  input  logic       rst_n,
  pvlr_in_if.sink    in_if,
  pvlr_out_if.source out_if
);

  pvlr_pkg::ctrl_cmd_t  cmd;
  pvlr_pkg::dp_status_t status;
  pvlr_pkg::pos_t       pos [pvlr_pkg::JOINTS];

  assign pos[0] = in_if.position_0;
  assign pos[1] = in_if.position_1;
  assign pos[2] = in_if.position_2;
  assign pos[3] = in_if.position_3;
  assign pos[4] = in_if.position_4;
  assign pos[5] = in_if.position_5;

  pvlr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pvlr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .pos_in        (pos),
    .edge_valid_in (in_if.edge_valid),
    .last_in       (in_if.last_point),
    .status        (status),
    .ratio_out     (out_if.violation_ratio),
    .total_out     (out_if.path_length)
  );

endmodule

// ----- tb/sv/pvlr_tb_checker.sv -----
// result checker for the path violation length ratio block: watches both
// channels, predicts path results and compares; depends on pvlr_pkg, pvlr_if
`timescale 1ns / 1ps

module pvlr_tb_checker (
  input  logic    clk,
  input  logic    rst_n,
  pvlr_in_if      in_if,
  pvlr_out_if     out_if,
  output int      fail_count,
  output int      pending,
  output int      paths_seen
);

  typedef struct {
    logic [pvlr_pkg::RATIO_W-1:0] ratio;
    logic [pvlr_pkg::SUM_W-1:0]   total;
  } path_result_t;

  path_result_t                          result_q[$];
  logic signed [pvlr_pkg::POS_W-1:0]     prev_pos[pvlr_pkg::JOINTS];
  logic                                  have_prev;
  logic [pvlr_pkg::SUM_W-1:0]            len_acc;
  logic [pvlr_pkg::SUM_W-1:0]            bad_acc;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic [pvlr_pkg::SUM_W-1:0] add_sat(
      input logic [pvlr_pkg::SUM_W-1:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = {24'd0, a} + b;
    return (s > {24'd0, pvlr_pkg::SUM_MAX}) ? pvlr_pkg::SUM_MAX : s[pvlr_pkg::SUM_W-1:0];
  endfunction

  task automatic take_point(input logic signed [pvlr_pkg::POS_W-1:0] p[pvlr_pkg::JOINTS],
                            input logic ok, input logic fin);
    logic [63:0] sq, d, a;
    logic signed [pvlr_pkg::POS_W:0] diff;
    path_result_t r;
    if (have_prev) begin
      sq = 0;
      for (int j = 0; j < pvlr_pkg::JOINTS; j++) begin
        diff = p[j] - prev_pos[j];
        a = diff < 0 ? 64'(-diff) : 64'(diff);
        sq += a * a;
      end
      d = int_sqrt(sq);
      len_acc = add_sat(len_acc, d);
      if (!ok) bad_acc = add_sat(bad_acc, d);
    end
    for (int j = 0; j < pvlr_pkg::JOINTS; j++) prev_pos[j] = p[j];
    have_prev = 1'b1;
    if (fin) begin
      r.total = len_acc;
      r.ratio = (len_acc == 0) ? '0 :
                pvlr_pkg::RATIO_W'(({24'd0, bad_acc} << pvlr_pkg::RATIO_FRAC) /
                                   {24'd0, len_acc});
      result_q.push_back(r);
      have_prev = 1'b0;
      len_acc = '0;
      bad_acc = '0;
    end
  endtask

  always @(posedge clk) begin
    logic signed [pvlr_pkg::POS_W-1:0] p[pvlr_pkg::JOINTS];
    path_result_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      len_acc = '0;
      bad_acc = '0;
      have_prev = 1'b0;
      result_q.delete();
      fail_count <= 0;
      paths_seen <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        p[0] = in_if.position_0; p[1] = in_if.position_1;
        p[2] = in_if.position_2; p[3] = in_if.position_3;
        p[4] = in_if.position_4; p[5] = in_if.position_5;
        take_point(p, in_if.edge_valid, in_if.last_point);
      end
      if (out_if.valid && out_if.ready) begin
        paths_seen <= paths_seen + 1;
        if (result_q.size() == 0) begin
          $error("unexpected result ratio=%0d path_length=%0d",
                 out_if.violation_ratio, out_if.path_length);
          errs++;
        end else begin
          e = result_q.pop_front();
          if (out_if.violation_ratio !== e.ratio) begin
            $error("violation_ratio expected %0d actual %0d", e.ratio,
                   out_if.violation_ratio);
            errs++;
          end
          if (out_if.path_length !== e.total) begin
            $error("path_length expected %0d actual %0d", e.total,
                   out_if.path_length);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
    pending <= result_q.size();
  end
endmodule

// ----- tb/sv/testbench.sv -----
// stimulus and verdict for the path violation length ratio block
// depends on pvlr_pkg, pvlr_if, pvlr_tb_checker and the block itself
`timescale 1ns / 1ps

module testbench;

  logic clk, rst_n;
  int   fail_count, pending, paths_seen;
  int   send_idle, recv_idle;
  int   hold_cycles;
  logic hold_done;
  int   sent;

  pvlr_in_if  in_if ();
  pvlr_out_if out_if ();

  path_violation_length_ratio uut (.clk(clk), .rst_n(rst_n), .in_if(in_if),
                                   .out_if(out_if));
  pvlr_tb_checker chk (.clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
                       .fail_count(fail_count), .pending(pending),
                       .paths_seen(paths_seen));

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off once the directed paths are in
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_cycles  <= 0;
      hold_done    <= 1'b0;
    end else if (!hold_done && sent >= 25) begin
      hold_done    <= 1'b1;
      hold_cycles  <= 2000;
      out_if.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic pvlr_pkg::pos_t pick_pos(input int mode);
    case (mode)
      0: return 24'sh7fffff;
      1: return -24'sh800000;
      2: return 24'sd0;
      3: return pvlr_pkg::pos_t'($urandom_range(2000) - 1000);
      default: return pvlr_pkg::pos_t'($urandom);
    endcase
  endfunction

  task automatic send(input pvlr_pkg::pos_t p[pvlr_pkg::JOINTS], input logic ok,
                      input logic fin);
    in_if.valid <= 1'b1;
    in_if.position_0 <= p[0]; in_if.position_1 <= p[1];
    in_if.position_2 <= p[2]; in_if.position_3 <= p[3];
    in_if.position_4 <= p[4]; in_if.position_5 <= p[5];
    in_if.edge_valid <= ok;
    in_if.last_point <= fin;
    do @(posedge clk); while (!in_if.ready);
    sent++;
    if ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(40, 1)) @(posedge clk);
    end
  endtask

  task automatic send_path(input int npts, input int mode);
    pvlr_pkg::pos_t p[pvlr_pkg::JOINTS];
    for (int k = 0; k < npts; k++) begin
      for (int j = 0; j < pvlr_pkg::JOINTS; j++)
        p[j] = (mode == 6) ? ((k % 2) ? 24'sh7fffff : -24'sh800000)
                           : pick_pos(mode == 5 ? $urandom_range(4) : mode);
      send(p, 1'($urandom_range(1)), k == npts - 1);
    end
  endtask

  initial begin
    pvlr_pkg::pos_t p[pvlr_pkg::JOINTS];
    int wait_cnt;
    rst_n = 0;
    sent = 0;
    send_idle = 8;
    recv_idle = 48;
    in_if.valid = 0;
    in_if.position_0 = 0; in_if.position_1 = 0; in_if.position_2 = 0;
    in_if.position_3 = 0; in_if.position_4 = 0; in_if.position_5 = 0;
    in_if.edge_valid = 0;
    in_if.last_point = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // single-point path, zero-length path, a path whose only invalid edge has zero length, all-invalid edges
    send_path(1, 0);
    send_path(3, 2);
    for (int j = 0; j < pvlr_pkg::JOINTS; j++) p[j] = 24'sh7fffff;
    send(p, 1, 0);
    for (int j = 0; j < pvlr_pkg::JOINTS; j++) p[j] = -24'sh800000;
    send(p, 1, 0);
    send(p, 0, 1);
    for (int j = 0; j < pvlr_pkg::JOINTS; j++) p[j] = -24'sh800000;
    send(p, 0, 0);
    for (int j = 0; j < pvlr_pkg::JOINTS; j++) p[j] = 24'sh7fffff;
    send(p, 0, 1);
    send_path(4, 3);
    // long alternating extreme path, largest possible edges
    send_path(12, 6);

    // receiver holds off here while the sender keeps offering points
    send_path(3, 4);
    send_path(2, 5);
    send_path(1, 5);

    while (sent < 700) begin
      if (sent > 280 && sent < 480) begin
        send_idle = 48; recv_idle = 8;
      end else if (sent >= 480) begin
        send_idle = 0; recv_idle = 0;
      end
      send_path($urandom_range(6, 1), $urandom_range(5));
    end
    in_if.valid <= 1'b0;

    wait_cnt = 0;
    while ((pending != 0 || hold_cycles != 0) && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (100) @(posedge clk);
    $display("covered %0d points in %0d paths, incl. single-point, zero-length,", sent,
             paths_seen);
    $display("maximum-edge paths and a long output stall");
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
